// ----- rtl/tmcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared widths, operation and character codes, and the control structs that
// pass between the text console sequencer and its cursor unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmcw_pkg;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 7;
    localparam int CURSOR_W  = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ATTR_W-1:0] t_attr;
    typedef logic [CELL_W-1:0] t_cell;

    localparam t_op OP_PUT   = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    localparam t_char CH_BS    = 8'h08;
    localparam t_char CH_HT    = 8'h09;
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_SPACE = 8'h20;

    localparam t_attr ATTR_RESET = 8'h0F;
    localparam t_cell CELL_RESET = {ATTR_RESET, CH_SPACE};

    // Command from the sequencer to the cursor unit.
    typedef struct packed {
        logic  put;
        logic  home;
        t_char code;
    } t_cur_cmd;

    // What the cursor unit reports about the command in flight.
    typedef struct packed {
        logic wr;
        logic scroll;
    } t_cur_stat;

endpackage

// ----- rtl/tmcw_if.sv -----
// ----------------------------------------------------------------------------
// tmcw_if
// Valid/ready channels of the text console: the operation item going in and
// the result item coming out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmcw_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmcw_pkg::OP_W-1:0]            operation;
    logic [tmcw_pkg::CHAR_W-1:0]          char_code;
    logic [tmcw_pkg::ROW_IN_W-1:0]        cell_row;
    logic [tmcw_pkg::COL_IN_W-1:0]        cell_column;

    modport source (output valid, output operation, output char_code,
                    output cell_row, output cell_column, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_row, input cell_column, output ready);
endinterface

interface tmcw_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmcw_pkg::CURSOR_W-1:0]        cursor_index;
    logic [tmcw_pkg::CELL_W-1:0]          cell_data;

    modport source (output valid, output cursor_index, output cell_data,
                    input ready);
    modport sink   (input valid, input cursor_index, input cell_data,
                    output ready);
endinterface

// ----- rtl/text_mode_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Text console engine: a screen of 16-bit cells (attribute over character)
// with a cursor, driven by put-character, clear and read-cell items.
//
// i_item carries one operation; o_result returns one item per operation with
// the cursor index after it and, for a read, the cell. i_cfg_we/i_cfg_wdata
// load the attribute used for written and blank cells.
// For put character, read cell and the unused code the item is accepted and
// the result is loaded in S_RESP once the output register is free.
// A put that scrolls first copies all rows but the first one row up through
// the screen memory's one read and one write port, then blanks the bottom row.
// Clear writes the blank cell over the whole screen, one cell per cycle.
// i_item.ready is high only while the engine is idle.
// After reset the engine fills the screen with 0x0F20 and takes no item
// until the fill is done.
// If the receiver stalls, the result waits in the output register; one more
// item may be accepted, and its result waits until the first is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_console_writer #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tmcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    tmcw_in_if.sink                       i_item,
    tmcw_out_if.source                    o_result
);

    localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CUR_W = tmcw_pkg::CURSOR_W;
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_RESP       = 3'd1;
    localparam logic [2:0] S_SCROLL     = 3'd2;
    localparam logic [2:0] S_SCROLL_END = 3'd3;
    localparam logic [2:0] S_FILL       = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_rd, n_rd;
    logic [AW-1:0]         r_wa, n_wa;
    logic                  r_wv, n_wv;
    logic [AW-1:0]         r_sweep, n_sweep;
    logic                  r_init, n_init;
    tmcw_pkg::t_op         r_op, n_op;
    logic                  r_inr, n_inr;
    tmcw_pkg::t_attr       r_attr;
    logic                  r_out_valid, n_out_valid;
    logic [CUR_W-1:0]      r_out_cursor;
    tmcw_pkg::t_cell       r_out_data;

    logic                  accept;
    logic                  load;
    logic                  in_range;
    logic [AW-1:0]         rd_addr_in;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    tmcw_pkg::t_cell       ram_wdata, ram_rdata;
    tmcw_pkg::t_cur_cmd    cur_cmd;
    tmcw_pkg::t_cur_stat   cur_stat;
    logic [AW-1:0]         cur_lin;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;

    assign in_range   = (32'(i_item.cell_row) < SCREEN_ROWS) &&
                        (32'(i_item.cell_column) < SCREEN_COLUMNS);
    assign rd_addr_in = AW'(i_item.cell_row) * AW'(SCREEN_COLUMNS) + AW'(i_item.cell_column);

    assign cur_cmd.put  = accept && (i_item.operation == tmcw_pkg::OP_PUT);
    assign cur_cmd.home = accept && (i_item.operation == tmcw_pkg::OP_CLEAR);
    assign cur_cmd.code = i_item.char_code;

    tmcw_cursor #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TAB_STOP       (TAB_STOP)
    ) u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cur_cmd),
        .o_stat  (cur_stat),
        .o_lin   (cur_lin)
    );

    tmcw_ram #(
        .WIDTH (tmcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_rd      = r_rd;
        n_wa      = r_wa;
        n_wv      = r_wv;
        n_sweep   = r_sweep;
        n_init    = r_init;
        n_op      = r_op;
        n_inr     = r_inr;
        load      = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_in;
        ram_we    = 1'b0;
        ram_waddr = cur_lin;
        ram_wdata = {r_attr, i_item.char_code};
        unique case (r_state)
            S_IDLE: begin
                // The cell read and the character write both happen at accept.
                ram_re = accept;
                ram_we = cur_stat.wr;
                if (accept) begin
                    n_op  = i_item.operation;
                    n_inr = in_range;
                    if (i_item.operation == tmcw_pkg::OP_CLEAR) begin
                        n_sweep = '0;
                        n_init  = 1'b0;
                        n_state = S_FILL;
                    end else if (cur_stat.scroll) begin
                        n_rd    = AW'(SCREEN_COLUMNS);
                        n_wv    = 1'b0;
                        n_state = S_SCROLL;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCROLL: begin
                // Read one row below, write the cell read in the last cycle.
                ram_re    = 1'b1;
                ram_raddr = r_rd;
                ram_we    = r_wv;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
                n_wa      = r_rd - AW'(SCREEN_COLUMNS);
                n_wv      = 1'b1;
                if (r_rd == LAST) begin
                    n_state = S_SCROLL_END;
                end else begin
                    n_rd = r_rd + AW'(1);
                end
            end
            S_SCROLL_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
                n_sweep   = AW'(CELLS - SCREEN_COLUMNS);
                n_init    = 1'b0;
                n_state   = S_FILL;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = r_init ? tmcw_pkg::CELL_RESET : {r_attr, tmcw_pkg::CH_SPACE};
                if (r_sweep == LAST) begin
                    n_state = r_init ? S_IDLE : S_RESP;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_result.ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_sweep     <= '0;
            r_init      <= 1'b1;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_attr      <= tmcw_pkg::ATTR_RESET;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_init      <= n_init;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_wa  <= n_wa;
        r_op  <= n_op;
        r_inr <= n_inr;
        if (load) begin
            r_out_cursor <= CUR_W'(cur_lin);
            r_out_data   <= (r_op == tmcw_pkg::OP_READ && r_inr) ? ram_rdata : '0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.cursor_index = r_out_cursor;
    assign o_result.cell_data    = r_out_data;

`ifndef SYNTH
    a_idle_write_only_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && ram_we) |->
            (accept && i_item.operation == tmcw_pkg::OP_PUT))
        else $error("screen written while idle without a put item");

    a_scroll_pipe_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_wv) |-> (r_wa + AW'(SCREEN_COLUMNS) + AW'(1) == r_rd))
        else $error("scroll write address out of step with read address");

    a_resp_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !o_result.ready) |=>
            (r_state == S_RESP && r_out_valid))
        else $error("result slot overwritten while stalled");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("engine stayed idle after accepting an item");
`endif

endmodule

// ----- rtl/tmcw_ram.sv -----
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tmcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tmcw_cursor
// Cursor unit: holds column, row and the column's position within its tab
// stop, applies one put-character or home command, and gives the linear index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcw_cursor #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 8,
    localparam int AW            = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmcw_pkg::t_cur_cmd   i_cmd,
    output tmcw_pkg::t_cur_stat  o_stat,
    output logic [AW-1:0]        o_lin
);

    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int XW    = $clog2(SCREEN_COLUMNS + TAB_STOP);
    localparam int PW    = $clog2(TAB_STOP);
    localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

    logic [CW-1:0] r_col,   n_col;
    logic [RW-1:0] r_row,   n_row;
    logic [PW-1:0] r_phase, n_phase;

    logic [XW-1:0] x_col;
    logic [RW:0]   x_row;
    logic [PW-1:0] x_phase;

    always_comb begin
        x_col   = XW'(r_col);
        x_row   = (RW + 1)'(r_row);
        x_phase = r_phase;
        o_stat  = '0;
        if (i_cmd.home) begin
            x_col   = '0;
            x_row   = '0;
            x_phase = '0;
        end else if (i_cmd.put) begin
            case (i_cmd.code)
                tmcw_pkg::CH_BS: begin
                    if (r_col != '0) begin
                        x_col   = XW'(r_col) - XW'(1);
                        x_phase = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
                    end
                end
                tmcw_pkg::CH_HT: begin
                    // The phase is the column modulo the tab stop.
                    x_col   = XW'(r_col) + XW'(TAB_STOP) - XW'(r_phase);
                    x_phase = '0;
                end
                tmcw_pkg::CH_CR: begin
                    x_col   = '0;
                    x_phase = '0;
                end
                tmcw_pkg::CH_LF: begin
                    x_col   = '0;
                    x_phase = '0;
                    x_row   = (RW + 1)'(r_row) + (RW + 1)'(1);
                end
                default: begin
                    if (i_cmd.code >= tmcw_pkg::CH_SPACE) begin
                        o_stat.wr = 1'b1;
                        x_col     = XW'(r_col) + XW'(1);
                        x_phase   = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
                    end
                end
            endcase
            if (x_col >= XW'(SCREEN_COLUMNS)) begin
                x_col   = '0;
                x_phase = '0;
                x_row   = x_row + (RW + 1)'(1);
            end
            if (x_row >= (RW + 1)'(SCREEN_ROWS)) begin
                o_stat.scroll = 1'b1;
                x_row         = (RW + 1)'(SCREEN_ROWS - 1);
            end
        end
        n_col   = CW'(x_col);
        n_row   = RW'(x_row);
        n_phase = x_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    assign o_lin = AW'(r_row) * AW'(SCREEN_COLUMNS) + AW'(r_col);

`ifndef SYNTH
    a_lin_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(o_lin) < CELLS)
        else $error("cursor index left the screen");

    a_scroll_keeps_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && o_stat.scroll) |=> (r_row == RW'(SCREEN_ROWS - 1)))
        else $error("cursor not on the last row after a scroll");
`endif

endmodule

// ----- dv/tb_text_mode_console_writer.sv -----
// ----------------------------------------------------------------------------
// tb_text_mode_console_writer
// Self-checking bench for the text console engine. A behavioral screen and
// cursor model predicts the cursor index and cell of every operation item.
// Directed tests cover reset contents, control codes, tab stops and the text
// attribute. Random phrase traffic then fills, wraps, scrolls and clears the
// screen under several attributes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_mode_console_writer;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int TAB   = 8;
    localparam int CELLS = COLS * ROWS;

    localparam tmcw_pkg::t_op OP_UNUSED = 2'd3;
    localparam int  RANDOM_PHASE_ITEMS = 462;

    typedef logic [tmcw_pkg::ROW_IN_W-1:0] t_row_in;
    typedef logic [tmcw_pkg::COL_IN_W-1:0] t_col_in;
    typedef logic [tmcw_pkg::CURSOR_W-1:0] t_cursor_idx;

    typedef struct packed {
        t_cursor_idx     cursor;
        tmcw_pkg::t_cell data;
    } t_console_result;

    typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} t_stall_mode;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    tmcw_pkg::t_attr cfg_wdata;

    tmcw_in_if  item_if ();
    tmcw_out_if result_if ();

    text_mode_console_writer #(
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS   (ROWS),
        .TAB_STOP      (TAB)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // Screen and cursor model.
    tmcw_pkg::t_cell screen_model [0:CELLS-1];
    int unsigned     cur_col;
    int unsigned     cur_row;
    tmcw_pkg::t_attr text_attr;

    t_console_result console_results_due [$];

    int unsigned failures;
    int unsigned results_seen;
    int unsigned n_items;
    int unsigned n_puts;
    int unsigned n_clears;
    int unsigned n_reads;
    int unsigned n_scrolls;
    int unsigned n_attr_writes;
    int unsigned burst_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic log_failure(string what);
        failures++;
        if (failures <= 10) begin
            $display("%0t ERROR %s", $time, what);
        end
    endtask

    function automatic t_console_result predict_console_op(tmcw_pkg::t_op op,
                                                           tmcw_pkg::t_char ch,
                                                           t_row_in row,
                                                           t_col_in col);
        t_console_result res;
        res.data = '0;
        n_items++;
        case (op)
            tmcw_pkg::OP_PUT: begin
                n_puts++;
                if (ch == tmcw_pkg::CH_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (ch == tmcw_pkg::CH_HT) begin
                    cur_col = (cur_col / TAB + 1) * TAB;
                end else if (ch == tmcw_pkg::CH_CR) begin
                    cur_col = 0;
                end else if (ch == tmcw_pkg::CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch >= tmcw_pkg::CH_SPACE) begin
                    if (cur_row * COLS + cur_col < CELLS) begin
                        screen_model[cur_row * COLS + cur_col] = {text_attr, ch};
                    end
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // Falling off the bottom row shifts every row up by one.
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLS; i++) begin
                        screen_model[i] = screen_model[i + COLS];
                    end
                    for (int i = CELLS - COLS; i < CELLS; i++) begin
                        screen_model[i] = {text_attr, tmcw_pkg::CH_SPACE};
                    end
                    cur_row = ROWS - 1;
                    n_scrolls++;
                end
            end
            tmcw_pkg::OP_CLEAR: begin
                n_clears++;
                for (int i = 0; i < CELLS; i++) begin
                    screen_model[i] = {text_attr, tmcw_pkg::CH_SPACE};
                end
                cur_col = 0;
                cur_row = 0;
            end
            tmcw_pkg::OP_READ: begin
                n_reads++;
                if (row < ROWS && col < COLS) begin
                    res.data = screen_model[row * COLS + col];
                end
            end
            default: ;
        endcase
        res.cursor = t_cursor_idx'(cur_row * COLS + cur_col);
        return res;
    endfunction

    // Drives one operation item and records its expected result once accepted.
    task automatic send_op(tmcw_pkg::t_op op, tmcw_pkg::t_char ch, t_row_in row,
                           t_col_in col);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                @(negedge clk);
                item_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        item_if.valid       = 1'b1;
        item_if.operation   = op;
        item_if.char_code   = ch;
        item_if.cell_row    = row;
        item_if.cell_column = col;
        do @(posedge clk); while (!item_if.ready);
        console_results_due.push_back(predict_console_op(op, ch, row, col));
    endtask

    task automatic put_char(tmcw_pkg::t_char ch);
        send_op(tmcw_pkg::OP_PUT, ch, t_row_in'($urandom), t_col_in'($urandom));
    endtask

    task automatic read_cell(int unsigned row, int unsigned col);
        send_op(tmcw_pkg::OP_READ, tmcw_pkg::t_char'($urandom), t_row_in'(row),
                t_col_in'(col));
    endtask

    task automatic clear_screen();
        send_op(tmcw_pkg::OP_CLEAR, tmcw_pkg::t_char'($urandom), t_row_in'($urandom),
                t_col_in'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_if.valid = 1'b0;
        burst_left = 0;
        while (console_results_due.size() != 0) @(posedge clk);
    endtask

    task automatic set_attribute(tmcw_pkg::t_attr value);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        text_attr = value;
        n_attr_writes++;
    endtask

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        read_cell(31, 127);
        send_op(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
    endtask

    task automatic test_control_codes();
        put_char(8'hFF);
        put_char(tmcw_pkg::CH_SPACE);
        put_char(8'h7F);
        put_char(tmcw_pkg::CH_BS);
        put_char(tmcw_pkg::CH_CR);
        put_char(tmcw_pkg::CH_BS);        // already at column 0, so the cursor stays
        put_char(8'h00);
        put_char(8'h1F);
        put_char(tmcw_pkg::CH_LF);
        read_cell(0, 0);
    endtask

    task automatic test_tab_stops();
        put_char(8'h41);
        put_char(tmcw_pkg::CH_HT);
        put_char(tmcw_pkg::CH_HT);
    endtask

    task automatic test_attribute();
        set_attribute(8'h00);
        put_char(8'h41);
        read_cell(1, 0);
        clear_screen();
        read_cell(ROWS - 1, COLS - 1);
        set_attribute(8'hFF);
        put_char(8'h80);
        read_cell(0, 0);
    endtask

    task automatic read_random_cell();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        end else if (pick < 8) begin
            read_cell(cur_row, $urandom_range(0, cur_col));
        end else begin
            read_cell($urandom_range(0, 31), $urandom_range(0, 127));
        end
    endtask

    // Random traffic is built from phrases: runs of text, tab runs, line ends,
    // backspaces, control codes and reads, with rare clears and do-nothing items mixed in.
    task automatic run_random_phase(int unsigned target);
        int unsigned counted;
        int unsigned pick;
        int unsigned len;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 12);
                repeat (len) put_char(tmcw_pkg::t_char'($urandom_range(32, 255)));
                counted += len;
            end else if (pick < 56) begin
                len = $urandom_range(1, 4);
                repeat (len) read_random_cell();
                counted += len;
            end else if (pick < 64) begin
                len = $urandom_range(1, 11);
                repeat (len) put_char(tmcw_pkg::CH_HT);
                counted += len;
            end else if (pick < 72) begin
                put_char(tmcw_pkg::CH_LF);
                counted++;
            end else if (pick < 78) begin
                put_char(tmcw_pkg::CH_CR);
                put_char(tmcw_pkg::CH_LF);
                counted += 2;
            end else if (pick < 82) begin
                put_char(tmcw_pkg::CH_CR);
                counted++;
            end else if (pick < 88) begin
                len = $urandom_range(1, 6);
                repeat (len) put_char(tmcw_pkg::CH_BS);
                counted += len;
            end else if (pick < 94) begin
                put_char(tmcw_pkg::t_char'($urandom_range(0, 31)));
                counted++;
            end else if (pick < 97) begin
                send_op(OP_UNUSED, tmcw_pkg::t_char'($urandom), t_row_in'($urandom),
                        t_col_in'($urandom));
                counted++;
            end else if (pick < 98) begin
                clear_screen();
                counted++;
            end else begin
                read_cell(cur_row, cur_col);
                counted++;
            end
        end
    endtask

    task automatic test_random_traffic();
        set_attribute(tmcw_pkg::t_attr'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS);
        set_attribute(8'hFF);
        run_random_phase(RANDOM_PHASE_ITEMS);
        set_attribute(8'h00);
        run_random_phase(RANDOM_PHASE_ITEMS);
        set_attribute(tmcw_pkg::t_attr'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS);
    endtask

    // Result receiver: switches between random stall patterns.
    initial begin
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned stall_left;
        int unsigned tick;
        mode       = STALL_NONE;
        mode_left  = 0;
        stall_left = 0;
        tick       = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            tick++;
            case (mode)
                STALL_NONE:     result_if.ready = 1'b1;
                STALL_COIN:     result_if.ready = 1'($urandom_range(0, 1));
                STALL_PERIODIC: result_if.ready = (tick % 4) != 0;
                STALL_LONG: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        result_if.ready = 1'b0;
                    end else begin
                        result_if.ready = 1'b1;
                        if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
                    end
                end
                default: result_if.ready = 1'b1;
            endcase
        end
    end

    always @(posedge clk) begin
        t_console_result want;
        if (rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (console_results_due.size() == 0) begin
                log_failure($sformatf("result with none expected: cursor %0d cell %h",
                                      result_if.cursor_index, result_if.cell_data));
            end else begin
                want = console_results_due.pop_front();
                if (result_if.cursor_index !== want.cursor ||
                    result_if.cell_data !== want.data) begin
                    log_failure($sformatf("cursor_index exp %0d got %0d, cell_data exp %h got %h",
                                          want.cursor, result_if.cursor_index,
                                          want.data, result_if.cell_data));
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d results still outstanding.",
                 console_results_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_if.valid        = 1'b0;
        item_if.operation    = tmcw_pkg::OP_PUT;
        item_if.char_code    = '0;
        item_if.cell_row     = '0;
        item_if.cell_column  = '0;
        failures      = 0;
        results_seen  = 0;
        n_items       = 0;
        n_puts        = 0;
        n_clears      = 0;
        n_reads       = 0;
        n_scrolls     = 0;
        n_attr_writes = 0;
        burst_left    = 0;
        cur_col       = 0;
        cur_row       = 0;
        text_attr     = tmcw_pkg::ATTR_RESET;
        for (int i = 0; i < CELLS; i++) screen_model[i] = tmcw_pkg::CELL_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_control_codes();
        test_tab_stops();
        test_attribute();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        if (console_results_due.size() != 0) begin
            log_failure($sformatf("%0d results never arrived", console_results_due.size()));
        end

        $display("Checked %0d results for %0d items: %0d puts, %0d clears, %0d reads.",
                 results_seen, n_items, n_puts, n_clears, n_reads);
        $display("Screen scrolled %0d times across %0d attribute settings; %0d failures.",
                 n_scrolls, n_attr_writes, failures);
        if (failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
